@@ rtl/framed_command_receiver_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros used by the framed command receiver checker.
// ----------------------------------------------------------------------------
`ifndef FRAMED_COMMAND_RECEIVER_DEFINES_SVH
`define FRAMED_COMMAND_RECEIVER_DEFINES_SVH

// The antecedent at one edge implies the consequent at the next edge.
`define FCR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// The antecedent implies the consequent at the same edge.
`define FCR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ rtl/fcr_pkg.sv @@
// ----------------------------------------------------------------------------
// fcr_pkg
// Constants and types shared by the framed command receiver modules.
// ----------------------------------------------------------------------------
package fcr_pkg;

    localparam int PAYLOAD_MAX = 16;
    localparam int SLOT_COUNT  = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int LEN_W       = $clog2(PAYLOAD_MAX + 1);

    localparam logic [7:0] START_IN       = 8'hAA;
    localparam logic [7:0] START_OUT      = 8'hBB;
    localparam logic [7:0] OP_RELAY       = 8'h01;
    localparam logic [7:0] OP_SEND        = 8'h02;
    localparam logic [7:0] OP_LEARN       = 8'h03;
    localparam logic [7:0] OP_STATUS      = 8'h04;
    localparam logic [7:0] STATUS_UNKNOWN = 8'hFF;

    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_SEND  = 2'd1;
    localparam logic [1:0] ACT_LEARN = 2'd2;

    // A checked frame, reduced to what command execution needs.
    typedef struct packed {
        logic [7:0] cmd;
        logic       has_first;
        logic       has_second;
        logic [7:0] first;
        logic [7:0] second;
    } cmd_t;

endpackage

@@ rtl/fcr_parser.sv @@
// ----------------------------------------------------------------------------
// fcr_parser
// Frame parser: tracks the frame phase, keeps the running XOR and the
// leading payload words, and pushes a command when the check word matches.
// ----------------------------------------------------------------------------
module fcr_parser
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [7:0]          rx_byte,
    input  logic                q_full,
    output logic                push,
    output fcr_pkg::cmd_t       push_cmd
);

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_CMD   = 3'd1;
    localparam logic [2:0] PH_LEN   = 3'd2;
    localparam logic [2:0] PH_DATA  = 3'd3;
    localparam logic [2:0] PH_CHECK = 3'd4;

    logic [2:0]                 phase_reg, phase_next;
    logic [7:0]                 cmd_reg, cmd_next;
    logic [fcr_pkg::LEN_W-1:0]  len_reg, len_next;
    logic [fcr_pkg::LEN_W-1:0]  count_reg, count_next;
    logic [7:0]                 chk_reg, chk_next;
    logic [7:0]                 first_reg, first_next;
    logic [7:0]                 second_reg, second_next;
    logic                       accept;
    logic [fcr_pkg::LEN_W-1:0]  count_inc;

    assign in_ready  = !q_full;
    assign accept    = in_valid && in_ready;
    assign count_inc = count_reg + fcr_pkg::LEN_W'(1);

    always_comb
    begin
        phase_next  = phase_reg;
        cmd_next    = cmd_reg;
        len_next    = len_reg;
        count_next  = count_reg;
        chk_next    = chk_reg;
        first_next  = first_reg;
        second_next = second_reg;
        push        = 1'b0;
        if (accept)
        begin
            unique case (phase_reg)
                PH_CMD:
                begin
                    cmd_next   = rx_byte;
                    chk_next   = rx_byte;
                    phase_next = PH_LEN;
                end
                PH_LEN:
                begin
                    if ({1'b0, rx_byte} > 9'(fcr_pkg::PAYLOAD_MAX))
                    begin
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        len_next   = fcr_pkg::LEN_W'(rx_byte);
                        chk_next   = chk_reg ^ rx_byte;
                        count_next = '0;
                        phase_next = (rx_byte == 8'd0) ? PH_CHECK : PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    // Only the first two payload words are ever used.
                    if (count_reg == fcr_pkg::LEN_W'(0))
                    begin
                        first_next = rx_byte;
                    end
                    if (count_reg == fcr_pkg::LEN_W'(1))
                    begin
                        second_next = rx_byte;
                    end
                    count_next = count_inc;
                    chk_next   = chk_reg ^ rx_byte;
                    if (count_inc >= len_reg)
                    begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK:
                begin
                    phase_next = PH_IDLE;
                    push       = (rx_byte == chk_reg);
                end
                default:
                begin
                    phase_next = (rx_byte == fcr_pkg::START_IN) ? PH_CMD : PH_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        push_cmd.cmd        = cmd_reg;
        push_cmd.has_first  = (len_reg >= fcr_pkg::LEN_W'(1));
        push_cmd.has_second = (len_reg >= fcr_pkg::LEN_W'(2));
        push_cmd.first      = first_reg;
        push_cmd.second     = second_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            len_reg   <= '0;
            count_reg <= '0;
            chk_reg   <= '0;
            cmd_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            count_reg <= count_next;
            chk_reg   <= chk_next;
            cmd_reg   <= cmd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg  <= first_next;
        second_reg <= second_next;
    end

endmodule

@@ rtl/fcr_queue.sv @@
// ----------------------------------------------------------------------------
// fcr_queue
// Short command queue between the parser and the executor.
// ----------------------------------------------------------------------------
module fcr_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  fcr_pkg::cmd_t  push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           q_valid,
    output fcr_pkg::cmd_t  q_cmd
);

    fcr_pkg::cmd_t                  entry_reg [fcr_pkg::QUEUE_DEPTH];
    logic [fcr_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [fcr_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [fcr_pkg::QCNT_W-1:0]     count_reg, count_next;
    logic                           do_pop;

    assign full    = (count_reg == fcr_pkg::QCNT_W'(fcr_pkg::QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_cmd   = entry_reg[rd_ptr_reg];
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == fcr_pkg::QPTR_W'(fcr_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + fcr_pkg::QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == fcr_pkg::QPTR_W'(fcr_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + fcr_pkg::QPTR_W'(1);
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + fcr_pkg::QCNT_W'(1);
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - fcr_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ rtl/fcr_exec.sv @@
// ----------------------------------------------------------------------------
// fcr_exec
// Command executor: runs a queued command, owns the relay state and sends
// the four-word response through a registered output stage.
// ----------------------------------------------------------------------------
module fcr_exec
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  fcr_pkg::cmd_t  q_cmd,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [7:0]     response_byte,
    output logic           response_last,
    output logic [1:0]     relay_bits,
    output logic [1:0]     radio_action,
    output logic [2:0]     radio_slot
);

    logic        busy_reg;
    logic [1:0]  idx_reg, idx_next;
    logic [7:0]  cmd_reg;
    logic [7:0]  status_reg;
    logic [7:0]  chk_reg;
    logic [1:0]  relay_reg, relay_next;
    logic [1:0]  action_reg, action_next;
    logic [2:0]  slot_reg, slot_next;
    logic [7:0]  status_next;
    logic [7:0]  first;
    logic [1:0]  mask;
    logic        last_taken;

    assign out_valid     = busy_reg;
    assign response_last = (idx_reg == 2'd3);
    assign relay_bits    = relay_reg;
    assign radio_action  = action_reg;
    assign radio_slot    = slot_reg;
    assign last_taken    = busy_reg && out_ready && response_last;
    assign pop           = q_valid && (!busy_reg || last_taken);
    assign first         = q_cmd.has_first ? q_cmd.first : 8'd0;

    always_comb
    begin
        unique case (idx_reg)
            2'd0:    response_byte = fcr_pkg::START_OUT;
            2'd1:    response_byte = cmd_reg;
            2'd2:    response_byte = status_reg;
            default: response_byte = chk_reg;
        endcase
    end

    always_comb
    begin
        relay_next  = relay_reg;
        action_next = fcr_pkg::ACT_NONE;
        slot_next   = 3'd0;
        status_next = 8'd0;
        mask        = 2'b00;
        if (first == 8'd1)
        begin
            mask = 2'b01;
        end
        else if (first == 8'd2)
        begin
            mask = 2'b10;
        end
        unique case (q_cmd.cmd)
            fcr_pkg::OP_RELAY:
            begin
                if (q_cmd.has_second)
                begin
                    relay_next  = (q_cmd.second != 8'd0) ? (relay_reg | mask)
                                                         : (relay_reg & ~mask);
                    status_next = {6'd0, relay_next};
                end
            end
            fcr_pkg::OP_SEND, fcr_pkg::OP_LEARN:
            begin
                if (q_cmd.has_first && ({1'b0, first} < 9'(fcr_pkg::SLOT_COUNT)))
                begin
                    action_next = (q_cmd.cmd == fcr_pkg::OP_SEND) ? fcr_pkg::ACT_SEND
                                                                  : fcr_pkg::ACT_LEARN;
                    slot_next   = first[2:0];
                    status_next = first;
                end
            end
            fcr_pkg::OP_STATUS:
            begin
                status_next = {6'd0, relay_reg};
            end
            default:
            begin
                status_next = fcr_pkg::STATUS_UNKNOWN;
            end
        endcase
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (pop)
        begin
            idx_next = 2'd0;
        end
        else if (busy_reg && out_ready)
        begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            idx_reg    <= 2'd0;
            relay_reg  <= 2'b00;
            action_reg <= fcr_pkg::ACT_NONE;
            slot_reg   <= 3'd0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (pop)
            begin
                busy_reg   <= 1'b1;
                relay_reg  <= relay_next;
                action_reg <= action_next;
                slot_reg   <= slot_next;
            end
            else if (last_taken)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg    <= q_cmd.cmd;
            status_reg <= status_next;
            chk_reg    <= fcr_pkg::START_OUT ^ q_cmd.cmd ^ status_next;
        end
    end

endmodule

@@ rtl/framed_command_receiver.sv @@
// ----------------------------------------------------------------------------
// framed_command_receiver
// Serial command frame receiver with XOR check and four-word responses.
// ----------------------------------------------------------------------------
// The receiver takes one received word per cycle on the rx channel and parses
// frames of start word 0xAA, command, length (0 to 16), payload and an XOR
// check word. Every checked frame becomes one queued command; the executor
// updates the relays or raises a radio request and sends the response
// 0xBB, command, status, check, one word per cycle when the sink is ready.
// A two-entry command queue sits between parser and executor; in_ready drops
// only while that queue is full, and the next response starts in the cycle
// after the previous last word is taken if a command is queued. There is no
// initialization pass after reset.
module framed_command_receiver
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  response_byte,
    output logic        response_last,
    output logic [1:0]  relay_bits,
    output logic [1:0]  radio_action,
    output logic [2:0]  radio_slot
);

    logic           push;
    fcr_pkg::cmd_t  push_cmd;
    logic           q_full;
    logic           pop;
    logic           q_valid;
    fcr_pkg::cmd_t  q_cmd;

    fcr_parser u_parser
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .rx_byte  (rx_byte),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    fcr_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    fcr_exec u_exec
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_cmd         (q_cmd),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .response_byte (response_byte),
        .response_last (response_last),
        .relay_bits    (relay_bits),
        .radio_action  (radio_action),
        .radio_slot    (radio_slot)
    );

endmodule

@@ rtl/fcr_checker.sv @@
// ----------------------------------------------------------------------------
// fcr_checker
// Port-level checks on the response channel of the receiver.
// ----------------------------------------------------------------------------
`include "framed_command_receiver_defines.svh"

module fcr_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  response_byte,
    input  logic        response_last,
    input  logic [1:0]  relay_bits,
    input  logic [1:0]  radio_action,
    input  logic [2:0]  radio_slot
);

    // A stalled response word stays offered unchanged.
    `FCR_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(response_byte), "stalled response word changed")

    // The words of one response follow each other without a gap.
    `FCR_ASSERT_NEXT(a_no_gap, out_valid && out_ready && !response_last, out_valid, "gap inside a response")

    // Relay and radio fields are the same on every word of one response.
    `FCR_ASSERT_NEXT(a_side_stable, out_valid && out_ready && !response_last, $stable(relay_bits) && $stable(radio_action) && $stable(radio_slot), "side fields changed inside a response")

    // No radio request means no slot.
    `FCR_ASSERT_NOW(a_slot_idle, out_valid && (radio_action == 2'd0), radio_slot == 3'd0, "slot set without radio request")

endmodule

bind framed_command_receiver fcr_checker u_fcr_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .response_byte (response_byte),
    .response_last (response_last),
    .relay_bits    (relay_bits),
    .radio_action  (radio_action),
    .radio_slot    (radio_slot)
);

@@ verif/framed_command_receiver_tb.sv @@
// ----------------------------------------------------------------------------
// framed_command_receiver_tb
// Streams command frames into the receiver and checks every response word.
// ----------------------------------------------------------------------------
// A short directed sequence covers each command and the main corner cases.
// It is followed by random frames: mostly well formed, with some bad checks,
// oversized lengths, cut-off frames and line noise in between. A frame parser
// inside the bench tracks the relays and predicts each four-word response,
// which the monitor compares field by field. Both sides stall at random, and
// twice the sink holds off long enough to fill the command queue.
module framed_command_receiver_tb;

    localparam int RANDOM_WORDS = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 200000;

    typedef enum logic [2:0] {
        WAIT_START,
        GET_CMD,
        GET_LEN,
        GET_DATA,
        GET_CHECK
    } rx_phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic [1:0] relays;
        logic [1:0] action;
        logic [2:0] slot;
    } response_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  rx_byte = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  response_byte;
    logic        response_last;
    logic [1:0]  relay_bits;
    logic [1:0]  radio_action;
    logic [2:0]  radio_slot;

    // Stimulus words and the responses they are predicted to cause.
    logic [7:0]  rx_stream[$];
    response_t   pending_responses[$];
    logic [7:0]  body[0:fcr_pkg::PAYLOAD_MAX-1];

    // Frame parser state of the prediction.
    rx_phase_t   rx_phase = WAIT_START;
    logic [7:0]  rx_cmd = 8'h00;
    logic [4:0]  rx_len = 5'd0;
    int          rx_count = 0;
    logic [7:0]  rx_data[0:fcr_pkg::PAYLOAD_MAX-1];
    logic [7:0]  rx_sum = 8'h00;
    logic [1:0]  relays = 2'b00;

    int          mismatches = 0;
    int          frames_run = 0;
    int          words_checked = 0;
    int          words_taken = 0;
    int          in_stall_cycles = 0;
    int          cycle_count = 0;
    int          hold_left = 0;
    int          holds_done = 0;
    int          send_wait = 0;
    int          recv_wait = 0;
    bit          send_calm = 1'b0;
    bit          recv_calm = 1'b0;
    logic        next_valid;
    response_t   want;

    framed_command_receiver i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .response_byte (response_byte),
        .response_last (response_last),
        .relay_bits    (relay_bits),
        .radio_action  (radio_action),
        .radio_slot    (radio_slot)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0d] MISMATCH: %s", cycle_count, msg);
        mismatches++;
    endtask

    // Appends a complete frame built from the first len words of body.
    task automatic push_frame(input logic [7:0] cmd, input int len, input bit spoil);
        logic [7:0] sum;
        int i;
        sum = cmd ^ 8'(len);
        rx_stream.push_back(fcr_pkg::START_IN);
        rx_stream.push_back(cmd);
        rx_stream.push_back(8'(len));
        for (i = 0; i < len; i++)
        begin
            rx_stream.push_back(body[i]);
            sum ^= body[i];
        end
        if (spoil)
            sum ^= 8'($urandom_range(1, 255));
        rx_stream.push_back(sum);
    endtask

    // Advances the frame parser by one accepted word and queues any response.
    task automatic parse_rx_byte(input logic [7:0] b);
        logic [7:0] status;
        logic [7:0] first;
        logic [1:0] act;
        logic [2:0] slot;
        logic [1:0] mask;
        response_t  r;
        int k;
        case (rx_phase)
            GET_CMD:
            begin
                rx_cmd = b;
                rx_sum = b;
                rx_phase = GET_LEN;
            end
            GET_LEN:
            begin
                if (b > fcr_pkg::PAYLOAD_MAX)
                    rx_phase = WAIT_START;
                else
                begin
                    rx_len = b[4:0];
                    rx_sum ^= b;
                    rx_count = 0;
                    rx_phase = (b == 8'd0) ? GET_CHECK : GET_DATA;
                end
            end
            GET_DATA:
            begin
                if (rx_count < fcr_pkg::PAYLOAD_MAX)
                    rx_data[rx_count] = b;
                rx_count++;
                rx_sum ^= b;
                if (rx_count >= rx_len)
                    rx_phase = GET_CHECK;
            end
            GET_CHECK:
            begin
                rx_phase = WAIT_START;
                if (b == rx_sum)
                begin
                    status = 8'h00;
                    act = fcr_pkg::ACT_NONE;
                    slot = 3'd0;
                    first = (rx_len >= 1) ? rx_data[0] : 8'h00;
                    case (rx_cmd)
                        fcr_pkg::OP_RELAY:
                        begin
                            if (rx_len >= 2)
                            begin
                                mask = (first == 8'd1) ? 2'b01 :
                                       (first == 8'd2) ? 2'b10 : 2'b00;
                                if (rx_data[1] != 8'h00)
                                    relays = relays | mask;
                                else
                                    relays = relays & ~mask;
                                status = {6'b0, relays};
                            end
                        end
                        fcr_pkg::OP_SEND, fcr_pkg::OP_LEARN:
                        begin
                            if (rx_len >= 1 && first < fcr_pkg::SLOT_COUNT)
                            begin
                                act = (rx_cmd == fcr_pkg::OP_SEND) ? fcr_pkg::ACT_SEND
                                                                   : fcr_pkg::ACT_LEARN;
                                slot = first[2:0];
                                status = first;
                            end
                        end
                        fcr_pkg::OP_STATUS:
                            status = {6'b0, relays};
                        default:
                            status = fcr_pkg::STATUS_UNKNOWN;
                    endcase
                    for (k = 0; k < 4; k++)
                    begin
                        case (k)
                            0: r.data = fcr_pkg::START_OUT;
                            1: r.data = rx_cmd;
                            2: r.data = status;
                            default: r.data = fcr_pkg::START_OUT ^ rx_cmd ^ status;
                        endcase
                        r.last = (k == 3);
                        r.relays = relays;
                        r.action = act;
                        r.slot = slot;
                        pending_responses.push_back(r);
                    end
                    frames_run++;
                end
            end
            default:
                rx_phase = (b == fcr_pkg::START_IN) ? GET_CMD : WAIT_START;
        endcase
    endtask

    // Driver: presents one word at a time and feeds each accepted word to the parser.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_ready)
                in_stall_cycles++;
            if (in_valid && in_ready)
            begin
                parse_rx_byte(rx_byte);
                words_taken <= words_taken + 1;
            end
            next_valid = in_valid && !in_ready;
            if (!next_valid)
            begin
                if (send_wait != 0)
                    send_wait--;
                else if (rx_stream.size() != 0)
                begin
                    rx_byte <= rx_stream.pop_front();
                    next_valid = 1'b1;
                    if ($urandom_range(0, 31) == 0)
                        send_calm = ($urandom_range(0, 2) == 0);
                    // Keep offering words back to back while the sink holds off.
                    send_wait = (send_calm || hold_left != 0) ? 0 : $urandom_range(0, 19);
                end
            end
            in_valid <= next_valid;
        end
    end

    // Monitor: checks each accepted response word against the oldest prediction.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_responses.size() == 0)
                    report_mismatch($sformatf("unexpected response word 0x%02h",
                                              response_byte));
                else
                begin
                    want = pending_responses.pop_front();
                    if (response_byte !== want.data)
                        report_mismatch($sformatf("response_byte 0x%02h, expected 0x%02h",
                                                  response_byte, want.data));
                    if (response_last !== want.last)
                        report_mismatch($sformatf("response_last %b, expected %b",
                                                  response_last, want.last));
                    if (relay_bits !== want.relays)
                        report_mismatch($sformatf("relay_bits %b, expected %b",
                                                  relay_bits, want.relays));
                    if (radio_action !== want.action)
                        report_mismatch($sformatf("radio_action %0d, expected %0d",
                                                  radio_action, want.action));
                    if (radio_slot !== want.slot)
                        report_mismatch($sformatf("radio_slot %0d, expected %0d",
                                                  radio_slot, want.slot));
                end
                words_checked++;
                if ($urandom_range(0, 15) == 0)
                    recv_calm = ($urandom_range(0, 2) == 0);
                recv_wait = recv_calm ? 0 : $urandom_range(0, 19);
            end
            else if (recv_wait != 0)
                recv_wait--;
            out_ready <= (recv_wait == 0) && (hold_left == 0);
        end
    end

    // Long sink hold-offs, so that the command queue fills and rx stalls.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            holds_done <= 0;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if ((holds_done == 0 && words_taken >= 120) ||
                 (holds_done == 1 && words_taken >= 300))
        begin
            hold_left <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[%0d] timeout with %0d responses outstanding",
                     cycle_count, pending_responses.size());
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin : stimulus
        int directed_words;
        int ignored_words;
        int len;
        int cut;
        int i;
        int pick;
        logic [7:0] op;

        // Directed part: noise while idle, every command, an oversized length.
        rx_stream.push_back(8'hFF);
        push_frame(fcr_pkg::OP_STATUS, 0, 1'b0);
        body[0] = 8'd1;
        body[1] = 8'd1;
        push_frame(fcr_pkg::OP_RELAY, 2, 1'b0);
        body[0] = 8'd7;
        push_frame(fcr_pkg::OP_SEND, 1, 1'b0);
        body[0] = 8'd8;
        push_frame(fcr_pkg::OP_LEARN, 1, 1'b0);
        push_frame(fcr_pkg::STATUS_UNKNOWN, 0, 1'b0);
        rx_stream.push_back(fcr_pkg::START_IN);
        rx_stream.push_back(fcr_pkg::OP_RELAY);
        rx_stream.push_back(8'(fcr_pkg::PAYLOAD_MAX + 1));
        directed_words = rx_stream.size();
        ignored_words = 1;

        while (rx_stream.size() - ignored_words - directed_words < RANDOM_WORDS)
        begin
            pick = $urandom_range(0, 99);
            pick = $urandom_range(0, 9);
            case (pick)
                0, 1, 2: op = fcr_pkg::OP_RELAY;
                3, 4:    op = fcr_pkg::OP_SEND;
                5, 6:    op = fcr_pkg::OP_LEARN;
                7:       op = fcr_pkg::OP_STATUS;
                default: op = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(5, 255));
            endcase
            for (i = 0; i < fcr_pkg::PAYLOAD_MAX; i++)
                body[i] = 8'($urandom_range(0, 255));
            if (op == fcr_pkg::OP_RELAY)
            begin
                if ($urandom_range(0, 3) != 0)
                    body[0] = 8'($urandom_range(1, 2));
                if ($urandom_range(0, 1) == 0)
                    body[1] = 8'h00;
            end
            else if ((op == fcr_pkg::OP_SEND || op == fcr_pkg::OP_LEARN) &&
                     $urandom_range(0, 3) != 0)
                body[0] = 8'($urandom_range(0, 9));
            len = $urandom_range(0, 2);
            if (op == fcr_pkg::OP_RELAY && $urandom_range(0, 3) != 0)
                len = 2;
            if ($urandom_range(0, 7) == 0)
                len = ($urandom_range(0, 1) == 0) ? fcr_pkg::PAYLOAD_MAX
                                                  : $urandom_range(3, fcr_pkg::PAYLOAD_MAX - 1);

            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                // Line noise between frames; the parser drops it.
                repeat ($urandom_range(1, 3))
                begin
                    op = 8'($urandom_range(0, 255));
                    rx_stream.push_back((op == fcr_pkg::START_IN) ? 8'h00 : op);
                    ignored_words++;
                end
            end
            else if (pick < 14)
            begin
                rx_stream.push_back(fcr_pkg::START_IN);
                rx_stream.push_back(op);
                rx_stream.push_back(8'($urandom_range(fcr_pkg::PAYLOAD_MAX + 1, 255)));
            end
            else if (pick < 20)
            begin
                // A frame cut off early; the next frame's words land inside it.
                len = $urandom_range(1, fcr_pkg::PAYLOAD_MAX);
                cut = $urandom_range(0, len - 1);
                rx_stream.push_back(fcr_pkg::START_IN);
                rx_stream.push_back(op);
                rx_stream.push_back(8'(len));
                for (i = 0; i < cut; i++)
                    rx_stream.push_back(body[i]);
            end
            else
                push_frame(op, len, $urandom_range(0, 9) == 0);
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (rx_stream.size() != 0 || in_valid)
            @(negedge clk);
        while (pending_responses.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Run covered %0d received words and %0d executed frames (%0d response words).",
                 words_taken, frames_run, words_checked);
        $display("The receiver stalled its input for %0d cycles during %0d long sink hold-offs.",
                 in_stall_cycles, holds_done);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
